// ----- hw/rtl/mva_pkg.sv -----
// Package for the MIDI voice allocator: beat types, command codes and constants.
`timescale 1ns / 1ps
package mva_pkg;

    localparam int NUM_VOICES_DEF             = 4;
    localparam int DECAY_TICKS_PER_UNIT_DEF   = 5;
    localparam int RELEASE_TICKS_PER_UNIT_DEF = 2;

    localparam int PERIOD_W = 20;

    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CONTROL  = 4'hB;
    localparam logic [3:0] ST_PITCH    = 4'hE;

    localparam logic [7:0] CC_VOLUME  = 8'h01;
    localparam logic [7:0] CC_REVERB  = 8'h14;
    localparam logic [7:0] CC_RELEASE = 8'h15;
    localparam logic [7:0] CC_DECAY   = 8'h16;
    localparam logic [7:0] CC_SUSTAIN = 8'h17;
    localparam logic [7:0] CC_MUTE    = 8'h30;
    localparam logic [7:0] MUTE_ON    = 8'h7F;

    localparam logic [7:0] VOLUME_RST  = 8'd64;
    localparam logic [7:0] VIBRATO_RST = 8'd64;
    localparam logic [7:0] SUSTAIN_RST = 8'd127;
    localparam logic [8:0] DECAY_RST   = 9'd1;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_ON,
        OP_OFF,
        OP_MUTE
    } t_op;

    typedef struct packed {
        logic       mode;
        logic [7:0] status_byte;
        logic [7:0] data_one;
        logic [7:0] data_two;
    } t_in;

    typedef struct packed {
        logic [15:0] voice_zero;
        logic [15:0] voice_one;
        logic [15:0] voice_two;
        logic [15:0] voice_three;
        logic [7:0]  master_level;
        logic [7:0]  reverb_out;
        logic [7:0]  vibrato_out;
    } t_out;

    typedef struct packed {
        t_op                 op;
        logic [7:0]          note;
        logic [7:0]          vel;
        logic                rel_nz;
        logic                any_rel;
        logic [PERIOD_W-1:0] rel_period;
        logic [PERIOD_W-1:0] dec_period;
        logic [7:0]          sustain;
    } t_cell_ctl;

    typedef struct packed {
        logic rel_hit;
        logic idle_hit;
        logic off_hit;
    } t_chain;

endpackage

// ----- hw/rtl/mva_cell.sv -----
// One voice cell: holds a voice word, its flags and its timer, and passes search tokens on.
`timescale 1ns / 1ps
module mva_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mva_pkg::t_cell_ctl i_ctl,
    input  mva_pkg::t_chain    i_chain,
    output mva_pkg::t_chain    o_chain,
    output logic [15:0]        o_word
);
    import mva_pkg::*;

    logic [15:0] r_word, n_word;
    logic        r_act, n_act;
    logic        r_rel, n_rel;
    logic [15:0] r_elapsed, n_elapsed;

    logic rel_match, idle_match, off_match;

    assign rel_match  = r_rel && (r_word[15:8] == i_ctl.note);
    assign idle_match = !r_act;
    assign off_match  = (r_word[15:8] == i_ctl.note);

    assign o_chain.rel_hit  = i_chain.rel_hit  | rel_match;
    assign o_chain.idle_hit = i_chain.idle_hit | idle_match;
    assign o_chain.off_hit  = i_chain.off_hit  | off_match;
    assign o_word = r_word;

    always_comb begin
        n_word    = r_word;
        n_act     = r_act;
        n_rel     = r_rel;
        n_elapsed = r_elapsed;
        unique case (i_ctl.op)
            OP_TICK: begin
                if (r_elapsed != TIMER_MAX) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
                if (r_rel && ({{(PERIOD_W-16){1'b0}}, n_elapsed} >= i_ctl.rel_period)) begin
                    n_elapsed = '0;
                    if (n_word[7:0] != 8'd0) begin
                        n_word = n_word - 16'd1;
                    end else begin
                        n_word = '0;
                        n_act  = 1'b0;
                        n_rel  = 1'b0;
                    end
                end
                if (n_act && ({{(PERIOD_W-16){1'b0}}, n_elapsed} >= i_ctl.dec_period)) begin
                    n_elapsed = '0;
                    if (n_word[7:0] > i_ctl.sustain) begin
                        n_word = n_word - 16'd1;
                    end else if (n_word[7:0] == 8'd0) begin
                        n_word = '0;
                        n_act  = 1'b0;
                    end
                end
            end
            OP_ON: begin
                if (rel_match && !i_chain.rel_hit) begin
                    n_rel     = 1'b0;
                    n_act     = 1'b1;
                    n_word    = {i_ctl.note, i_ctl.vel};
                    n_elapsed = '0;
                end else if (!i_ctl.any_rel && idle_match && !i_chain.idle_hit) begin
                    n_act     = 1'b1;
                    n_word    = {i_ctl.note, i_ctl.vel};
                    n_elapsed = '0;
                end
            end
            OP_OFF: begin
                if (off_match && !i_chain.off_hit) begin
                    if (i_ctl.rel_nz) begin
                        n_rel     = 1'b1;
                        n_elapsed = '0;
                    end else begin
                        n_word = '0;
                        n_act  = 1'b0;
                    end
                end
            end
            OP_MUTE: begin
                n_word = '0;
                n_act  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word    <= '0;
            r_act     <= 1'b0;
            r_rel     <= 1'b0;
            r_elapsed <= '0;
        end else begin
            r_word    <= n_word;
            r_act     <= n_act;
            r_rel     <= n_rel;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

// ----- hw/rtl/midi_voice_allocator_envelope_top.sv -----
// Top level of the MIDI voice allocator with release and decay envelopes.
`timescale 1ns / 1ps
// Each beat is a MIDI message or a 0.1 ms tick. A beat is taken when start is high and busy
// is low; busy then stays high for one cycle while the row of voice cells updates, and the
// result is shown on o_result with o_strobe high in the cycle after that. A new beat can be
// taken as soon as busy falls, in the cycle in which the last result is shown. The delay
// is set by the input register followed by the update of the cell row, in which the voice
// search tokens ripple from cell to cell. The receiver cannot stall the block: o_strobe
// marks each result for exactly one cycle.
module midi_voice_allocator_envelope_top #(
    parameter int NUM_VOICES             = mva_pkg::NUM_VOICES_DEF,
    parameter int DECAY_TICKS_PER_UNIT   = mva_pkg::DECAY_TICKS_PER_UNIT_DEF,
    parameter int RELEASE_TICKS_PER_UNIT = mva_pkg::RELEASE_TICKS_PER_UNIT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mva_pkg::t_in  i_item,
    output logic          o_strobe,
    output mva_pkg::t_out o_result
);
    import mva_pkg::*;

    logic        r_go;
    t_in         r_cmd;
    logic        r_strobe;
    logic [7:0]  r_volume;
    logic [7:0]  r_reverb;
    logic [7:0]  r_vibrato;
    logic [7:0]  r_release;
    logic [8:0]  r_decay;
    logic [7:0]  r_sustain;
    logic        r_skip;
    logic        r_mute;
    logic [PERIOD_W-1:0] r_rel_period;
    logic [PERIOD_W-1:0] r_dec_period;

    t_op         op;
    t_cell_ctl   ctl;
    t_chain      chain [NUM_VOICES+1];
    logic [15:0] words [NUM_VOICES];
    logic [15:0] shown [4];
    logic [3:0]  nib;

    assign nib  = r_cmd.status_byte[7:4];
    assign busy = r_go;
    assign o_strobe = r_strobe;

    always_comb begin
        op = OP_NONE;
        if (r_go) begin
            if (r_cmd.mode) begin
                op = OP_TICK;
            end else if (nib == ST_NOTE_ON) begin
                if (!r_skip && !r_mute) begin
                    op = OP_ON;
                end
            end else if (nib == ST_NOTE_OFF) begin
                op = OP_OFF;
            end else if (nib == ST_CONTROL && r_cmd.data_one == CC_MUTE
                         && r_cmd.data_two == MUTE_ON) begin
                op = OP_MUTE;
            end
        end
    end

    assign ctl.op         = op;
    assign ctl.note       = r_cmd.data_one;
    assign ctl.vel        = r_cmd.data_two;
    assign ctl.rel_nz     = (r_release != 8'd0);
    assign ctl.any_rel    = chain[NUM_VOICES].rel_hit;
    assign ctl.rel_period = r_rel_period;
    assign ctl.dec_period = r_dec_period;
    assign ctl.sustain    = r_sustain;

    assign chain[0] = '0;

    for (genvar v = 0; v < NUM_VOICES; v++) begin : g_cell
        mva_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_chain (chain[v]),
            .o_chain (chain[v+1]),
            .o_word  (words[v])
        );
    end

    for (genvar k = 0; k < 4; k++) begin : g_show
        if (k < NUM_VOICES) begin : g_on
            assign shown[k] = words[k];
        end else begin : g_off
            assign shown[k] = '0;
        end
    end

    assign o_result.voice_zero   = shown[0];
    assign o_result.voice_one    = shown[1];
    assign o_result.voice_two    = shown[2];
    assign o_result.voice_three  = shown[3];
    assign o_result.master_level = r_volume;
    assign o_result.reverb_out   = r_reverb;
    assign o_result.vibrato_out  = r_vibrato;

    always_ff @(posedge i_clk) begin
        r_rel_period <= PERIOD_W'(r_release) * PERIOD_W'(RELEASE_TICKS_PER_UNIT);
        r_dec_period <= PERIOD_W'(r_decay) * PERIOD_W'(DECAY_TICKS_PER_UNIT);
        if (start && !r_go) begin
            r_cmd <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go      <= 1'b0;
            r_strobe  <= 1'b0;
            r_volume  <= VOLUME_RST;
            r_reverb  <= '0;
            r_vibrato <= VIBRATO_RST;
            r_release <= '0;
            r_decay   <= DECAY_RST;
            r_sustain <= SUSTAIN_RST;
            r_skip    <= 1'b1;
            r_mute    <= 1'b0;
        end else begin
            r_go     <= start && !r_go;
            r_strobe <= r_go;
            if (r_go && !r_cmd.mode) begin
                if (nib == ST_NOTE_ON && r_skip) begin
                    r_skip <= 1'b0;
                end
                if (nib == ST_PITCH) begin
                    r_vibrato <= r_cmd.data_two;
                end
                if (nib == ST_CONTROL) begin
                    unique case (r_cmd.data_one)
                        CC_VOLUME:  r_volume  <= r_cmd.data_two;
                        CC_REVERB:  r_reverb  <= r_cmd.data_two;
                        CC_RELEASE: r_release <= r_cmd.data_two;
                        CC_DECAY:   r_decay   <= {1'b0, r_cmd.data_two} + 9'd1;
                        CC_SUSTAIN: r_sustain <= r_cmd.data_two;
                        CC_MUTE:    r_mute    <= (r_cmd.data_two == MUTE_ON);
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

endmodule

// ----- hw/rtl/mva_checker.sv -----
// Port-level checker for the MIDI voice allocator, bound to the top level.
`timescale 1ns / 1ps
module mva_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input mva_pkg::t_out o_result
);
    import mva_pkg::*;

    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) ##1 i_rst_n |=> o_strobe)
        else $error("accepted beat gave no result");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a beat in work");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_idle_at_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("block busy while result shown");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> $stable(o_result))
        else $error("result changed in the cycle after it was shown");

endmodule

bind midi_voice_allocator_envelope_top mva_checker u_mva_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
